[hdl/c8df_pkg.sv]
// Package for the CRC-8 packet deframer: shared constants, the result struct
// and the byte-wide CRC-8 fold. No dependencies.
package c8df_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 64;
  localparam int HEADER_BYTES_DEF    = 3;

  localparam int BYTE_W     = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [BYTE_W-1:0] POLY_RESET = 8'h07;

  localparam logic REG_CRC_POLY = 1'b0;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t data_byte;
    byte_t position;
    logic  kept;
    logic  frame_end;
    logic  frame_good;
  } res_t;

  function automatic byte_t crc8_fold(input byte_t crc, input byte_t b, input byte_t poly);
    byte_t v;
    v = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

[hdl/c8df_cfg.sv]
// APB-style configuration register for the CRC-8 packet deframer.
// Holds the CRC-8 polynomial; depends on c8df_pkg.
module c8df_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [c8df_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [c8df_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [c8df_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output c8df_pkg::byte_t                   crc_poly
);

  c8df_pkg::byte_t crc_poly_r;
  c8df_pkg::byte_t crc_poly_nxt;
  logic            reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[c8df_pkg::APB_ADDR_W-1];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    crc_poly_nxt = crc_poly_r;
    if (wr_en && reg_idx == c8df_pkg::REG_CRC_POLY) begin
      crc_poly_nxt = pwdata[c8df_pkg::BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r <= c8df_pkg::POLY_RESET;
    end else begin
      crc_poly_r <= crc_poly_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == c8df_pkg::REG_CRC_POLY) begin
      prdata = c8df_pkg::APB_DATA_W'(crc_poly_r);
    end
  end

  assign crc_poly = crc_poly_r;

endmodule

[hdl/c8df_parser.sv]
// Frame state of the CRC-8 packet deframer: position, announced length and
// running CRC, with the per-byte decision logic. Depends on c8df_pkg.
module c8df_parser #(
  parameter int MAX_FRAME_BYTES = c8df_pkg::MAX_FRAME_BYTES_DEF,
  parameter int HEADER_BYTES    = c8df_pkg::HEADER_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  c8df_pkg::byte_t rx_byte,
  input  c8df_pkg::byte_t crc_poly,
  output c8df_pkg::res_t  res
);

  localparam c8df_pkg::byte_t MAX_LEN = c8df_pkg::BYTE_W'(MAX_FRAME_BYTES);
  localparam c8df_pkg::byte_t MIN_LEN = c8df_pkg::BYTE_W'(HEADER_BYTES + 1);

  c8df_pkg::byte_t byte_index_r, byte_index_nxt;
  c8df_pkg::byte_t frame_length_r, frame_length_nxt;
  c8df_pkg::byte_t running_crc_r, running_crc_nxt;

  c8df_pkg::byte_t len_eff;
  c8df_pkg::byte_t idx_inc;
  c8df_pkg::byte_t crc_new;
  logic            drop;
  logic            last;

  always_comb begin
    len_eff = (byte_index_r == 8'd1) ? rx_byte : frame_length_r;
    drop    = (byte_index_r == 8'd0 && rx_byte != 8'd0) ||
              (len_eff < MIN_LEN) || (len_eff > MAX_LEN);
    idx_inc = byte_index_r + 8'd1;
    crc_new = c8df_pkg::crc8_fold(running_crc_r, rx_byte, crc_poly);
    last    = !drop && (idx_inc == len_eff);

    res.data_byte  = rx_byte;
    res.position   = byte_index_r;
    res.kept       = !drop;
    res.frame_end  = last;
    res.frame_good = last && (crc_new == 8'd0);

    byte_index_nxt   = byte_index_r;
    frame_length_nxt = frame_length_r;
    running_crc_nxt  = running_crc_r;
    if (step) begin
      if (drop || last) begin
        byte_index_nxt   = 8'd0;
        frame_length_nxt = MAX_LEN;
        running_crc_nxt  = 8'd0;
      end else begin
        byte_index_nxt   = idx_inc;
        frame_length_nxt = len_eff;
        running_crc_nxt  = crc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= 8'd0;
      frame_length_r <= MAX_LEN;
      running_crc_r  <= 8'd0;
    end else begin
      byte_index_r   <= byte_index_nxt;
      frame_length_r <= frame_length_nxt;
      running_crc_r  <= running_crc_nxt;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r < MAX_LEN)
    else $error("byte index beyond frame buffer");

  a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.frame_end |=> byte_index_r == 8'd0 && running_crc_r == 8'd0 &&
    frame_length_r == MAX_LEN)
    else $error("frame state not restarted after frame end");

  a_drop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && !res.kept |=> byte_index_r == 8'd0 && running_crc_r == 8'd0)
    else $error("frame state not restarted after dropped byte");

endmodule

[hdl/crc8_packet_deframer.sv]
// Top level of the CRC-8 packet deframer: input register, frame parser,
// result register and configuration port. Depends on c8df_pkg, c8df_cfg, c8df_parser.
//
// Takes one serial byte per transaction and returns one result per byte: the
// byte, its position in the frame, whether it was kept, and at the last byte of
// a frame whose second byte announced its length, a good flag when the CRC-8
// over the whole frame (check byte included) is zero. A transaction is accepted
// every cycle unless out_stall holds a full result register; each byte passes
// through the input register and the result register, and the frame state and
// byte-wide CRC update are combinational between them. The CRC polynomial (reset 0x07)
// is at address 0; the user writes it only while idle; the block does not enforce it.
module crc8_packet_deframer #(
  parameter int MAX_FRAME_BYTES = c8df_pkg::MAX_FRAME_BYTES_DEF,
  parameter int HEADER_BYTES    = c8df_pkg::HEADER_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_data_byte,
  output logic [7:0]                        out_position,
  output logic                              out_kept,
  output logic                              out_frame_end,
  output logic                              out_frame_good,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [c8df_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [c8df_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [c8df_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic            s1_valid_r, s1_valid_nxt;
  c8df_pkg::byte_t s1_byte_r;
  logic            out_valid_r, out_valid_nxt;
  c8df_pkg::res_t  out_res_r;
  c8df_pkg::res_t  res;
  c8df_pkg::byte_t crc_poly;
  logic            out_free;
  logic            step;
  logic            in_fire;

  c8df_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .crc_poly (crc_poly)
  );

  c8df_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .HEADER_BYTES    (HEADER_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (s1_byte_r),
    .crc_poly (crc_poly),
    .res      (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_rx_byte;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_res_r.data_byte;
  assign out_position   = out_res_r.position;
  assign out_kept       = out_res_r.kept;
  assign out_frame_end  = out_res_r.frame_end;
  assign out_frame_good = out_res_r.frame_good;

  a_good_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.frame_good && !out_res_r.frame_end))
    else $error("frame good without frame end");

  a_end_needs_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.frame_end |-> out_res_r.kept)
    else $error("frame end on dropped byte");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room downstream");

endmodule

[dv/crc8_packet_deframer_tb.sv]
// Self-checking testbench for crc8_packet_deframer: streams serial bytes and
// checks every per-byte result. Depends on c8df_pkg and the deframer RTL.
module crc8_packet_deframer_tb;

  localparam int MAX_BYTES      = c8df_pkg::MAX_FRAME_BYTES_DEF;
  localparam int HDR_BYTES      = c8df_pkg::HEADER_BYTES_DEF;
  localparam int REG_SPARE      = 1;
  localparam int PHASE_ITEMS    = 155;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_LINES   = 50;

  class deframe_scoreboard;
    c8df_pkg::byte_t poly_reg;
    c8df_pkg::byte_t cur_pos;
    c8df_pkg::byte_t announced_len;
    c8df_pkg::byte_t crc_acc;
    c8df_pkg::res_t  expected_results[$];
    int              errors;

    function new();
      poly_reg = c8df_pkg::POLY_RESET;
      errors   = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      cur_pos       = '0;
      announced_len = c8df_pkg::byte_t'(MAX_BYTES);
      crc_acc       = '0;
    endfunction

    function void write_reg(int index, logic [31:0] value);
      if (index == int'(c8df_pkg::REG_CRC_POLY)) begin
        poly_reg = value[7:0];
      end
    endfunction

    function c8df_pkg::byte_t fold_crc(c8df_pkg::byte_t crc, c8df_pkg::byte_t b);
      c8df_pkg::byte_t v;
      v = crc ^ b;
      for (int k = 0; k < c8df_pkg::BYTE_W; k++) begin
        v = v[c8df_pkg::BYTE_W-1] ? ((v << 1) ^ poly_reg) : (v << 1);
      end
      return v;
    endfunction

    function void note_byte(c8df_pkg::byte_t b);
      c8df_pkg::res_t r;
      r.data_byte  = b;
      r.position   = cur_pos;
      r.kept       = 1'b0;
      r.frame_end  = 1'b0;
      r.frame_good = 1'b0;
      if (cur_pos == 8'd1) begin
        announced_len = b;
      end
      if ((cur_pos == 8'd0 && b != 8'd0) || announced_len < HDR_BYTES + 1 ||
          announced_len > MAX_BYTES) begin
        clear_frame();
      end else begin
        r.kept  = 1'b1;
        cur_pos = cur_pos + 8'd1;
        crc_acc = fold_crc(crc_acc, b);
        if (cur_pos == announced_len) begin
          r.frame_end  = 1'b1;
          r.frame_good = (crc_acc == 8'd0);
          clear_frame();
        end
      end
      expected_results.push_back(r);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      if (errors < REPORT_LINES) begin
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
      end
      errors++;
    endtask

    task check_result(c8df_pkg::res_t got);
      c8df_pkg::res_t want;
      if (expected_results.size() == 0) begin
        report("result with no transaction pending", got.data_byte, 8'h00);
        return;
      end
      want = expected_results.pop_front();
      if (got.data_byte !== want.data_byte) begin
        report("data_byte", got.data_byte, want.data_byte);
      end
      if (got.position !== want.position) begin
        report("position", got.position, want.position);
      end
      if (got.kept !== want.kept) begin
        report("kept", {7'd0, got.kept}, {7'd0, want.kept});
      end
      if (got.frame_end !== want.frame_end) begin
        report("frame_end", {7'd0, got.frame_end}, {7'd0, want.frame_end});
      end
      if (got.frame_good !== want.frame_good) begin
        report("frame_good", {7'd0, got.frame_good}, {7'd0, want.frame_good});
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_position;
  logic        out_kept;
  logic        out_frame_end;
  logic        out_frame_good;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [c8df_pkg::APB_ADDR_W-1:0] paddr;
  logic [c8df_pkg::APB_DATA_W-1:0] pwdata;
  logic [c8df_pkg::APB_DATA_W-1:0] prdata;
  logic        pready;

  deframe_scoreboard sb = new();
  bit calm = 1'b0;
  int items_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;

  crc8_packet_deframer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_byte(out_data_byte),
    .out_position(out_position), .out_kept(out_kept), .out_frame_end(out_frame_end),
    .out_frame_good(out_frame_good),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_data_byte, out_position, out_kept, out_frame_end, out_frame_good});
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      out_stall = (stall_left > 0);
    end
  end

  task send_byte(input c8df_pkg::byte_t b);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  task send_frame(input c8df_pkg::byte_t body[$], input bit corrupt);
    c8df_pkg::byte_t frame[$];
    c8df_pkg::byte_t crc;
    int k;
    frame.push_back(8'h00);
    frame.push_back(c8df_pkg::byte_t'(body.size() + HDR_BYTES));
    foreach (body[i]) frame.push_back(body[i]);
    crc = '0;
    foreach (frame[i]) crc = sb.fold_crc(crc, frame[i]);
    frame.push_back(crc);
    if (corrupt) begin
      k = $urandom_range(2, frame.size() - 1);
      frame[k] = frame[k] ^ c8df_pkg::byte_t'(1 << $urandom_range(0, 7));
    end
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  task send_random_frame(input bit corrupt);
    c8df_pkg::byte_t body[$];
    int n;
    case ($urandom_range(0, 7))
      0: n = 1;
      1: n = MAX_BYTES - HDR_BYTES;
      default: n = $urandom_range(1, 20);
    endcase
    repeat (n) body.push_back(c8df_pkg::byte_t'($urandom));
    send_frame(body, corrupt);
  endtask

  task wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task write_reg(input int index, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = c8df_pkg::APB_ADDR_W'(index * 4);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(index, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task run_phase(input int quota);
    int start;
    int pick;
    int len;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_random_frame(1'b0);
      end else if (pick < 82) begin
        send_random_frame(1'b1);
      end else if (pick < 88) begin
        send_byte(8'h00);
        if ($urandom_range(0, 1) == 0) begin
          send_byte(c8df_pkg::byte_t'($urandom_range(0, HDR_BYTES)));
        end else begin
          send_byte(c8df_pkg::byte_t'($urandom_range(MAX_BYTES + 1, 255)));
        end
      end else if (pick < 94) begin
        len = $urandom_range(HDR_BYTES + 1, MAX_BYTES);
        send_byte(8'h00);
        send_byte(c8df_pkg::byte_t'(len));
        repeat ($urandom_range(0, len - 3)) send_byte(c8df_pkg::byte_t'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(c8df_pkg::byte_t'($urandom));
      end
    end
  endtask

  initial begin
    c8df_pkg::byte_t polys[6];
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    polys = '{8'h00, 8'hFF, 8'h31, c8df_pkg::byte_t'($urandom), 8'h80,
              c8df_pkg::POLY_RESET};
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // missing start, short and oversized lengths, then minimal frames and a two-byte-body frame
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h00); send_byte(8'd3);
    send_byte(8'h00); send_byte(8'd65);
    send_byte(8'h00); send_byte(8'hFF);
    send_byte(8'h00); send_byte(8'h00);
    send_frame({8'hFF}, 1'b0);
    send_frame({8'h00}, 1'b1);
    send_frame({8'h80, 8'h7F}, 1'b0);
    wait_drained();

    foreach (polys[p]) begin
      if (p == 2) begin
        write_reg(REG_SPARE, $urandom);
      end
      write_reg(int'(c8df_pkg::REG_CRC_POLY), {24'h0, polys[p]});
      calm = (p == $size(polys) - 1);
      run_phase(PHASE_ITEMS);
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
